@@ design/tic_pkg.sv @@
// Shared types and constants for the triangle iso-contour segment block.
// Used by tic_front, tic_queue, tic_back and the top level; no dependencies.
package tic_pkg;

  // Coordinate width and derived datapath widths
  localparam int CW     = 32;
  localparam int TOLW   = 16;
  localparam int DW     = CW + 1;   // signed difference of two coordinates
  localparam int MW     = CW;       // magnitude of such a difference
  localparam int NSTEP  = MW;       // one quotient bit per divider stage
  localparam int NMETA  = NSTEP + 3; // operand, magnitude, product, divide stages
  localparam int NLANE  = 4;        // start x, start y, end x, end y
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  // Configuration register indexes
  localparam int CFG_IW = 2;
  localparam logic [CFG_IW-1:0] REG_ISO = 2'd0;
  localparam logic [CFG_IW-1:0] REG_TOL = 2'd1;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_EDGE   = 2'd1,
    KIND_CROSS2 = 2'd2,
    KIND_CORNER = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    CLS_BELOW = 2'd0,
    CLS_ON    = 2'd1,
    CLS_ABOVE = 2'd2
  } cls_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } corner_t;

  // Classified triangle: each end point is a corner, or a crossing
  // measured from base toward oth
  typedef struct packed {
    kind_t   kind;
    logic    s_cross;
    logic    e_cross;
    corner_t s_base;
    corner_t s_oth;
    corner_t e_base;
    corner_t e_oth;
  } item_t;

endpackage

@@ design/tic_front.sv @@
// Front end: classifies the three corners against the on-depth band and
// picks the segment case and the end-point corners. Depends on tic_pkg.
module tic_front (
  input  logic signed [tic_pkg::CW-1:0]   ax,
  input  logic signed [tic_pkg::CW-1:0]   ay,
  input  logic signed [tic_pkg::CW-1:0]   az,
  input  logic signed [tic_pkg::CW-1:0]   bx,
  input  logic signed [tic_pkg::CW-1:0]   by_coord,
  input  logic signed [tic_pkg::CW-1:0]   bz,
  input  logic signed [tic_pkg::CW-1:0]   cx,
  input  logic signed [tic_pkg::CW-1:0]   cy,
  input  logic signed [tic_pkg::CW-1:0]   cz,
  input  logic signed [tic_pkg::CW-1:0]   iso_depth,
  input  logic        [tic_pkg::TOLW-1:0] tol,
  output tic_pkg::item_t                  item
);
  import tic_pkg::*;

  corner_t              v [3];
  cls_t                 c [3];
  logic signed [DW-1:0] band_lo;
  logic signed [DW-1:0] band_hi;
  logic signed [DW-1:0] zx [3];
  logic                 on0, on1, on2;
  logic [1:0]           k, m, n;

  assign v[0] = '{x: ax, y: ay,       z: az};
  assign v[1] = '{x: bx, y: by_coord, z: bz};
  assign v[2] = '{x: cx, y: cy,       z: cz};

  // Band edges, inclusive
  assign band_lo = {iso_depth[CW-1], iso_depth} - {{(DW-TOLW){1'b0}}, tol};
  assign band_hi = {iso_depth[CW-1], iso_depth} + {{(DW-TOLW){1'b0}}, tol};

  // Classify each corner
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      zx[i] = {v[i].z[CW-1], v[i].z};
      if (zx[i] < band_lo)      c[i] = CLS_BELOW;
      else if (zx[i] > band_hi) c[i] = CLS_ABOVE;
      else                      c[i] = CLS_ON;
    end
  end

  assign on0 = (c[0] == CLS_ON);
  assign on1 = (c[1] == CLS_ON);
  assign on2 = (c[2] == CLS_ON);

  // Odd corner and its two neighbors, in list order
  always_comb begin
    if (c[1] == c[2])      k = 2'd0;
    else if (c[0] == c[2]) k = 2'd1;
    else                   k = 2'd2;
    m = (k == 2'd0) ? 2'd1 : 2'd0;
    n = (k == 2'd2) ? 2'd1 : 2'd2;
  end

  // Pick the segment case, first match wins
  always_comb begin
    item = '0;
    if (c[0] == c[1] && c[1] == c[2]) begin
      item.kind = KIND_NONE;
    end else if (on0 && on1) begin
      item.kind   = KIND_EDGE;
      item.s_base = v[0];
      item.e_base = v[1];
    end else if (on1 && on2) begin
      item.kind   = KIND_EDGE;
      item.s_base = v[1];
      item.e_base = v[2];
    end else if (on2 && on0) begin
      item.kind   = KIND_EDGE;
      item.s_base = v[2];
      item.e_base = v[0];
    end else if (!on0 && !on1 && !on2) begin
      item.kind    = KIND_CROSS2;
      item.s_cross = 1'b1;
      item.e_cross = 1'b1;
      item.s_base  = v[k];
      item.s_oth   = v[m];
      item.e_base  = v[k];
      item.e_oth   = v[n];
    end else if (on0 && c[1] != c[2]) begin
      item.kind    = KIND_CORNER;
      item.s_base  = v[0];
      item.e_cross = 1'b1;
      item.e_base  = v[1];
      item.e_oth   = v[2];
    end else if (on1 && c[0] != c[2]) begin
      item.kind    = KIND_CORNER;
      item.s_base  = v[1];
      item.e_cross = 1'b1;
      item.e_base  = v[0];
      item.e_oth   = v[2];
    end else if (on2 && c[0] != c[1]) begin
      item.kind    = KIND_CORNER;
      item.s_base  = v[2];
      item.e_cross = 1'b1;
      item.e_base  = v[0];
      item.e_oth   = v[1];
    end
  end

endmodule

@@ design/tic_queue.sv @@
// Short register queue between the classifier and the crossing pipeline.
// Depends on tic_pkg for the item type and depth.
module tic_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tic_pkg::item_t wr_item,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output tic_pkg::item_t head
);
  import tic_pkg::*;

  item_t            mem_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QAW:0]     cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == (QAW+1)'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop)      cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QAW+1)'(QDEPTH))
    else $error("queue count above depth");

  a_cnt_up: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && do_push && !do_pop |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("queue count missed a push");

  a_cnt_down: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && do_pop && !do_push |=> cnt_r == $past(cnt_r) - 1'b1)
    else $error("queue count missed a pop");

endmodule

@@ design/tic_back.sv @@
// Back end: four interpolation lanes (difference, magnitude, multiply,
// 32-stage restoring divide, sign and offset) and the result register.
// Depends on tic_pkg.
module tic_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic signed [tic_pkg::CW-1:0] iso_depth,
  input  tic_pkg::item_t                head,
  input  logic                          q_empty,
  output logic                          q_pop,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic                          out_seg_valid,
  output logic [1:0]                    out_seg_kind,
  output logic signed [tic_pkg::CW-1:0] out_start_x,
  output logic signed [tic_pkg::CW-1:0] out_start_y,
  output logic signed [tic_pkg::CW-1:0] out_start_z,
  output logic signed [tic_pkg::CW-1:0] out_end_x,
  output logic signed [tic_pkg::CW-1:0] out_end_y,
  output logic signed [tic_pkg::CW-1:0] out_end_z
);
  import tic_pkg::*;

  typedef struct packed {
    kind_t                       kind;
    logic                        s_cross;
    logic                        e_cross;
    logic signed [CW-1:0]        s_z;
    logic signed [CW-1:0]        e_z;
    logic [NLANE-1:0]            neg;
    logic [NLANE-1:0][CW-1:0]    base;
  } meta_t;

  logic                 adv;
  logic [NMETA-1:0]     vld_r;
  meta_t                meta_r [NMETA];
  meta_t                meta0_nxt, meta1_nxt, last;

  logic signed [DW-1:0] t_r [NLANE], dz_r [NLANE], dv_r [NLANE];
  logic signed [DW-1:0] t_nxt [NLANE], dz_nxt [NLANE], dv_nxt [NLANE];
  logic [MW-1:0]        ma_r [NLANE], mb_r [NLANE], md_r [NLANE];
  logic [MW-1:0]        ma_nxt [NLANE], mb_nxt [NLANE], md_nxt [NLANE];
  logic [MW-1:0]        rem_r [NLANE][NSTEP+1], rem_nxt [NLANE][NSTEP+1];
  logic [MW-1:0]        ql_r  [NLANE][NSTEP+1], ql_nxt  [NLANE][NSTEP+1];
  logic [MW-1:0]        dd_r  [NLANE][NSTEP+1], dd_nxt  [NLANE][NSTEP+1];
  logic signed [CW-1:0] res [NLANE];

  logic                 out_valid_r;
  kind_t                out_kind_r;
  logic signed [CW-1:0] out_sx_r, out_sy_r, out_sz_r, out_ex_r, out_ey_r, out_ez_r;

  // Whole pipeline moves when the result register is free or drained
  assign adv       = !out_valid_r || out_pop;
  assign q_pop     = adv && !q_empty;
  assign out_empty = !out_valid_r;

  // Stage 0: lane operands and coordinate differences
  always_comb begin
    corner_t bc, oc;
    logic signed [CW-1:0] bv, ov;
    meta0_nxt         = '0;
    meta0_nxt.kind    = head.kind;
    meta0_nxt.s_cross = head.s_cross;
    meta0_nxt.e_cross = head.e_cross;
    meta0_nxt.s_z     = head.s_cross ? iso_depth : head.s_base.z;
    meta0_nxt.e_z     = head.e_cross ? iso_depth : head.e_base.z;
    for (int l = 0; l < NLANE; l++) begin
      bc = (l < 2) ? head.s_base : head.e_base;
      oc = (l < 2) ? head.s_oth  : head.e_oth;
      bv = (l % 2 == 1) ? bc.y : bc.x;
      ov = (l % 2 == 1) ? oc.y : oc.x;
      meta0_nxt.base[l] = bv;
      t_nxt[l]  = {iso_depth[CW-1], iso_depth} - {bc.z[CW-1], bc.z};
      dz_nxt[l] = {oc.z[CW-1], oc.z} - {bc.z[CW-1], bc.z};
      dv_nxt[l] = {ov[CW-1], ov} - {bv[CW-1], bv};
    end
  end

  // Stage 1: quotient sign and magnitudes
  always_comb begin
    logic [DW-1:0] nt, nz, nv;
    meta1_nxt = meta_r[0];
    for (int l = 0; l < NLANE; l++) begin
      nt = -t_r[l];
      nz = -dz_r[l];
      nv = -dv_r[l];
      meta1_nxt.neg[l] = t_r[l][DW-1] ^ dz_r[l][DW-1] ^ dv_r[l][DW-1];
      ma_nxt[l] = t_r[l][DW-1]  ? nt[MW-1:0] : t_r[l][MW-1:0];
      md_nxt[l] = dz_r[l][DW-1] ? nz[MW-1:0] : dz_r[l][MW-1:0];
      mb_nxt[l] = dv_r[l][DW-1] ? nv[MW-1:0] : dv_r[l][MW-1:0];
    end
  end

  // Stage 2: product; then one restoring divide step per stage
  always_comb begin
    logic [2*MW-1:0] prod;
    logic [MW:0]     sh, df;
    logic            ge;
    for (int l = 0; l < NLANE; l++) begin
      prod          = ma_r[l] * mb_r[l];
      rem_nxt[l][0] = prod[2*MW-1:MW];
      ql_nxt[l][0]  = prod[MW-1:0];
      dd_nxt[l][0]  = md_r[l];
      for (int s = 1; s <= NSTEP; s++) begin
        sh = {rem_r[l][s-1], ql_r[l][s-1][MW-1]};
        df = sh - {1'b0, dd_r[l][s-1]};
        ge = (sh >= {1'b0, dd_r[l][s-1]});
        rem_nxt[l][s] = ge ? df[MW-1:0] : sh[MW-1:0];
        ql_nxt[l][s]  = {ql_r[l][s-1][MW-2:0], ge};
        dd_nxt[l][s]  = dd_r[l][s-1];
      end
    end
  end

  // Shift payload through the stages
  always_ff @(posedge clk) begin
    if (adv) begin
      meta_r[0] <= meta0_nxt;
      meta_r[1] <= meta1_nxt;
      for (int i = 2; i < NMETA; i++) begin
        meta_r[i] <= meta_r[i-1];
      end
      t_r     <= t_nxt;
      dz_r    <= dz_nxt;
      dv_r    <= dv_nxt;
      ma_r    <= ma_nxt;
      mb_r    <= mb_nxt;
      md_r    <= md_nxt;
      rem_r   <= rem_nxt;
      ql_r    <= ql_nxt;
      dd_r    <= dd_nxt;
    end
  end

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NMETA-2:0], !q_empty};
    end
  end

  // Apply sign and offset from the base corner
  assign last = meta_r[NMETA-1];
  always_comb begin
    logic signed [CW-1:0] q;
    logic                 xing;
    for (int l = 0; l < NLANE; l++) begin
      q    = ql_r[l][NSTEP];
      xing = (l < 2) ? last.s_cross : last.e_cross;
      if (!xing)              res[l] = last.base[l];
      else if (last.neg[l])   res[l] = last.base[l] - q;
      else                    res[l] = last.base[l] + q;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld_r[NMETA-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_kind_r <= last.kind;
      out_sx_r   <= res[0];
      out_sy_r   <= res[1];
      out_sz_r   <= last.s_z;
      out_ex_r   <= res[2];
      out_ey_r   <= res[3];
      out_ez_r   <= last.e_z;
    end
  end

  assign out_seg_valid = (out_kind_r != KIND_NONE);
  assign out_seg_kind  = out_kind_r;
  assign out_start_x   = out_sx_r;
  assign out_start_y   = out_sy_r;
  assign out_start_z   = out_sz_r;
  assign out_end_x     = out_ex_r;
  assign out_end_y     = out_ey_r;
  assign out_end_z     = out_ez_r;

endmodule

@@ design/triangle_iso_contour_segment.sv @@
// Top level of the triangle iso-contour segment block: configuration
// registers, classifier, queue and crossing pipeline. Depends on tic_pkg.
//
// Usage:
//   Input channel: drive the nine corner fields with in_push high; a triangle
//   transfers at a rising edge where in_push is high and in_full is low.
//   Result channel: while out_empty is low the oldest segment sits on the
//   out_ ports; it transfers at an edge where out_pop is high.
//   Configuration: cfg_we with cfg_index 0 (iso depth) or 1 (tolerance)
//   writes cfg_wdata; other indexes are ignored. Write only while no
//   triangle is in flight.
// Timing:
//   One triangle per cycle sustained when nothing stalls. A triangle passes
//   the queue register, then three operand/multiply stages and 32 divider
//   stages (one quotient bit each) whose last feeds the result register.
// Reset (rst_n low, synchronous): queue, pipeline and result are emptied,
//   both configuration registers go to 0.
// Stall: when the result is not popped, the crossing pipeline holds, the
//   four-entry queue fills, and then in_full rises.
module triangle_iso_contour_segment (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_push,
  output logic                            in_full,
  input  logic signed [tic_pkg::CW-1:0]   in_ax,
  input  logic signed [tic_pkg::CW-1:0]   in_ay,
  input  logic signed [tic_pkg::CW-1:0]   in_az,
  input  logic signed [tic_pkg::CW-1:0]   in_bx,
  input  logic signed [tic_pkg::CW-1:0]   in_by_coord,
  input  logic signed [tic_pkg::CW-1:0]   in_bz,
  input  logic signed [tic_pkg::CW-1:0]   in_cx,
  input  logic signed [tic_pkg::CW-1:0]   in_cy,
  input  logic signed [tic_pkg::CW-1:0]   in_cz,
  input  logic                            cfg_we,
  input  logic [tic_pkg::CFG_IW-1:0]      cfg_index,
  input  logic [tic_pkg::CW-1:0]          cfg_wdata,
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic                            out_seg_valid,
  output logic [1:0]                      out_seg_kind,
  output logic signed [tic_pkg::CW-1:0]   out_start_x,
  output logic signed [tic_pkg::CW-1:0]   out_start_y,
  output logic signed [tic_pkg::CW-1:0]   out_start_z,
  output logic signed [tic_pkg::CW-1:0]   out_end_x,
  output logic signed [tic_pkg::CW-1:0]   out_end_y,
  output logic signed [tic_pkg::CW-1:0]   out_end_z
);
  import tic_pkg::*;

  logic signed [CW-1:0] iso_r;
  logic [TOLW-1:0]      tol_r;
  item_t                cls_item, head;
  logic                 q_empty, q_pop;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iso_r <= '0;
      tol_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ISO: iso_r <= cfg_wdata;
        REG_TOL: tol_r <= cfg_wdata[TOLW-1:0];
        default: ;
      endcase
    end
  end

  tic_front u_front (
    .ax        (in_ax),
    .ay        (in_ay),
    .az        (in_az),
    .bx        (in_bx),
    .by_coord  (in_by_coord),
    .bz        (in_bz),
    .cx        (in_cx),
    .cy        (in_cy),
    .cz        (in_cz),
    .iso_depth (iso_r),
    .tol       (tol_r),
    .item      (cls_item)
  );

  tic_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_push),
    .wr_item (cls_item),
    .full    (in_full),
    .pop     (q_pop),
    .empty   (q_empty),
    .head    (head)
  );

  tic_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .iso_depth     (iso_r),
    .head          (head),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_seg_valid (out_seg_valid),
    .out_seg_kind  (out_seg_kind),
    .out_start_x   (out_start_x),
    .out_start_y   (out_start_y),
    .out_start_z   (out_start_z),
    .out_end_x     (out_end_x),
    .out_end_y     (out_end_y),
    .out_end_z     (out_end_z)
  );

endmodule
